// File: src/bpa_pkg.sv
// bpa_pkg: shared types and codes of the bitmap page allocator
// used by the top level, front end, back end and checker; no dependencies

package bpa_pkg;

   // page numbers are carried at a fixed width that covers every supported
   // page size and page count, plus headroom for region end arithmetic
   localparam int PG_W  = 25;
   localparam int CNT_W = 21;

   localparam logic [2:0] ACT_ALLOC_ONE = 3'd0;
   localparam logic [2:0] ACT_ALLOC_RUN = 3'd1;
   localparam logic [2:0] ACT_ALLOC_DMA = 3'd2;
   localparam logic [2:0] ACT_FREE_ONE  = 3'd3;
   localparam logic [2:0] ACT_FREE_RUN  = 3'd4;
   localparam logic [2:0] ACT_MARK_USED = 3'd5;
   localparam logic [2:0] ACT_MARK_FREE = 3'd6;
   localparam logic [2:0] ACT_UNKNOWN   = 3'd7;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_ZERO    = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_DOUBLE  = 3'd4;
   localparam logic [2:0] ST_SKIPPED = 3'd5;

   localparam logic [1:0] CSR_TOTAL = 2'd0;
   localparam logic [1:0] CSR_FLOOR = 2'd1;
   localparam logic [1:0] CSR_DMA   = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_SEARCH,
      OP_SET,
      OP_CLR,
      OP_FREE
   } op_type;

   typedef enum logic [2:0] {
      BK_FILL,
      BK_IDLE,
      BK_RUN,
      BK_LOAD,
      BK_DONE
   } bk_state_type;

   typedef struct packed {
      op_type            op;
      logic              many;
      logic [2:0]        status;
      logic [PG_W-1:0]   first;
      logic [PG_W-1:0]   rem;
      logic [PG_W-1:0]   lim;
      logic [PG_W-1:0]   len;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] addr;
      logic [16:0] changed;
      logic [16:0] used;
      logic [16:0] free;
   } rsp_type;

endpackage

// File: src/bitmap_page_allocator_unit.sv
// bitmap_page_allocator_unit: top level of the bitmap page allocator
// depends on bpa_pkg, bpa_front, bpa_fifo and bpa_back
//
// usage
// - requests go in through a queue port: drive req_* and raise req_push;
//   an item is taken at a clock edge where req_push is high and req_full low
// - results come out through a queue port: the oldest result sits on rsp_*
//   while rsp_empty is low and leaves at an edge where rsp_pop is high
// - csr_write with csr_index/csr_data writes page count (0), search floor (1) or dma
//   limit (2); the user must write only while no request is outstanding; not enforced
// - a request walks the bitmap one page per cycle, pausing to load each
//   bitmap word it touches that is not the cached word; the back end takes
//   a new request only after the last result has entered the result queue
// - reset and every page count write run a sweep that writes ones to every
//   bitmap word, marking every page used; req_full stays high during the
//   sweep
// - a stalled receiver fills the two-entry result queue, then the back end
//   waits and the two-entry command queue backs up to req_full

module bitmap_page_allocator_unit
   import bpa_pkg::*;
#(
   parameter int MAX_PAGES  = 65536,
   parameter int PAGE_SHIFT = 12,
   parameter int WORD_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_byte_address,
   input  logic [31:0] req_region_bytes,
   input  logic [16:0] req_run_pages,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_address,
   output logic [16:0] rsp_pages_changed,
   output logic [16:0] rsp_used_count,
   output logic [16:0] rsp_free_count,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   localparam logic [PG_W-1:0] MAX_PG = PG_W'(MAX_PAGES);

   // configuration registers
   logic [PG_W-1:0] total_ff, total_in;
   logic [16:0]     floor_ff, floor_in, dma_ff, dma_in;
   logic            cfg_fill;

   // front to back queue
   cmd_type cmd_new, cmd_head;
   logic    cmd_full, cmd_empty, cmd_pop;

   // back to result queue
   rsp_type rsp_new, rsp_head;
   logic    rsp_full, rsp_push, fill_busy;

   assign cfg_fill = csr_write && (csr_index == CSR_TOTAL);

   always_comb begin
      total_in = total_ff;
      floor_in = floor_ff;
      dma_in   = dma_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TOTAL: total_in = (PG_W'(csr_data) > MAX_PG) ? MAX_PG : PG_W'(csr_data);
            CSR_FLOOR: floor_in = csr_data;
            CSR_DMA:   dma_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= (PG_W'(65536) > MAX_PG) ? MAX_PG : PG_W'(65536);
         floor_ff <= 17'd1024;
         dma_ff   <= 17'd4096;
      end else begin
         total_ff <= total_in;
         floor_ff <= floor_in;
         dma_ff   <= dma_in;
      end
   end

   // input side is blocked while the bitmap sweep runs
   assign req_full = cmd_full || fill_busy;

   bpa_front #(
      .PAGE_SHIFT(PAGE_SHIFT)
   ) u_front (
      .action      (req_action),
      .byte_address(req_byte_address),
      .region_bytes(req_region_bytes),
      .run_pages   (req_run_pages),
      .total_i     (total_ff),
      .floor_i     (floor_ff),
      .dma_i       (dma_ff),
      .cmd_o       (cmd_new)
   );

   bpa_fifo #(
      .W($bits(cmd_type))
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push && !fill_busy),
      .push_data(cmd_new),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_data (cmd_head),
      .empty    (cmd_empty)
   );

   bpa_back #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_SHIFT(PAGE_SHIFT),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_fill_i (cfg_fill),
      .total_i    (total_ff),
      .floor_i    (floor_ff),
      .cmd_i      (cmd_head),
      .cmd_empty_i(cmd_empty),
      .cmd_pop_o  (cmd_pop),
      .rsp_full_i (rsp_full),
      .rsp_push_o (rsp_push),
      .rsp_o      (rsp_new),
      .fill_busy_o(fill_busy)
   );

   bpa_fifo #(
      .W($bits(rsp_type))
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_new),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_data (rsp_head),
      .empty    (rsp_empty)
   );

   assign rsp_status         = rsp_head.status;
   assign rsp_result_address = rsp_head.addr;
   assign rsp_pages_changed  = rsp_head.changed;
   assign rsp_used_count     = rsp_head.used;
   assign rsp_free_count     = rsp_head.free;

endmodule

// File: src/bpa_fifo.sv
// bpa_fifo: two-entry queue of flat words
// used for the command and result queues; no dependencies

module bpa_fifo #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   logic [W-1:0] data_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: src/bpa_front.sv
// bpa_front: decodes a request into a page walk command
// depends on bpa_pkg

module bpa_front
   import bpa_pkg::*;
#(
   parameter int PAGE_SHIFT = 12
) (
   input  logic [2:0]      action,
   input  logic [31:0]     byte_address,
   input  logic [31:0]     region_bytes,
   input  logic [16:0]     run_pages,
   input  logic [PG_W-1:0] total_i,
   input  logic [16:0]     floor_i,
   input  logic [16:0]     dma_i,
   output cmd_type         cmd_o
);

   localparam logic [32:0] PG_M1 = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

   logic [PG_W-1:0] addr_pg, rnd_pg, up_pg, dn_pg, cnt_pg, floor_pg, dma_pg;
   logic [PG_W-1:0] end_u, end_uc, rem_u, first_f, end_f, end_fc, rem_f, dma_lim;
   logic [32:0]     addr_up, size_up;

   always_comb begin
      addr_pg  = PG_W'(byte_address >> PAGE_SHIFT);
      addr_up  = {1'b0, byte_address} + PG_M1;
      rnd_pg   = PG_W'(addr_up >> PAGE_SHIFT);
      size_up  = {1'b0, region_bytes} + PG_M1;
      up_pg    = PG_W'(size_up >> PAGE_SHIFT);
      dn_pg    = PG_W'(region_bytes >> PAGE_SHIFT);
      cnt_pg   = PG_W'(run_pages);
      floor_pg = PG_W'(floor_i);
      dma_pg   = PG_W'(dma_i);
      dma_lim  = (dma_pg < total_i) ? dma_pg : total_i;

      // mark_used: base rounded down, size rounded up
      end_u  = addr_pg + up_pg;
      end_uc = (end_u > total_i) ? total_i : end_u;
      rem_u  = (end_uc > addr_pg) ? end_uc - addr_pg : '0;

      // mark_free: base rounded up, size rounded down, page zero kept
      end_f   = rnd_pg + dn_pg;
      first_f = (rnd_pg == '0) ? PG_W'(1) : rnd_pg;
      end_fc  = (end_f > total_i) ? total_i : end_f;
      rem_f   = (end_fc > first_f) ? end_fc - first_f : '0;

      cmd_o        = '0;
      cmd_o.op     = OP_NOP;
      cmd_o.status = ST_OK;
      unique case (action)
         ACT_ALLOC_ONE: begin
            cmd_o.op    = OP_SEARCH;
            cmd_o.first = floor_pg;
            cmd_o.lim   = total_i;
            cmd_o.len   = PG_W'(1);
         end
         ACT_ALLOC_RUN: begin
            if (run_pages == '0) begin
               cmd_o.status = ST_ZERO;
            end else begin
               cmd_o.op    = OP_SEARCH;
               cmd_o.first = floor_pg;
               cmd_o.lim   = total_i;
               cmd_o.len   = cnt_pg;
            end
         end
         ACT_ALLOC_DMA: begin
            cmd_o.op    = OP_SEARCH;
            cmd_o.first = floor_pg;
            cmd_o.lim   = dma_lim;
            cmd_o.len   = PG_W'(1);
         end
         ACT_FREE_ONE: begin
            cmd_o.op    = OP_FREE;
            cmd_o.first = addr_pg;
            cmd_o.rem   = PG_W'(1);
         end
         ACT_FREE_RUN: begin
            cmd_o.op    = OP_FREE;
            cmd_o.many  = 1'b1;
            cmd_o.first = addr_pg;
            cmd_o.rem   = cnt_pg;
         end
         ACT_MARK_USED: begin
            cmd_o.op    = OP_SET;
            cmd_o.first = addr_pg;
            cmd_o.rem   = rem_u;
         end
         ACT_MARK_FREE: begin
            cmd_o.op    = OP_CLR;
            cmd_o.first = first_f;
            cmd_o.rem   = rem_f;
         end
         ACT_UNKNOWN: begin
            cmd_o.status = ST_INVALID;
         end
      endcase
   end

endmodule

// File: src/bpa_back.sv
// bpa_back: bitmap memory, one-word cache and page walk sequencer
// depends on bpa_pkg

module bpa_back
   import bpa_pkg::*;
#(
   parameter int MAX_PAGES  = 65536,
   parameter int PAGE_SHIFT = 12,
   parameter int WORD_BITS  = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cfg_fill_i,
   input  logic [PG_W-1:0] total_i,
   input  logic [16:0]     floor_i,
   input  cmd_type         cmd_i,
   input  logic            cmd_empty_i,
   output logic            cmd_pop_o,
   input  logic            rsp_full_i,
   output logic            rsp_push_o,
   output rsp_type         rsp_o,
   output logic            fill_busy_o
);

   localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WSH   = $clog2(WORD_BITS);
   localparam int AP_W  = 32 - PAGE_SHIFT;
   localparam logic [WIW-1:0] LAST_W = WIW'(WORDS - 1);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_ff;

   bk_state_type         state_ff, state_in;
   op_type               op_ff, op_in;
   logic                 many_ff, many_in;
   logic [2:0]           stat_ff, stat_in;
   logic [PG_W-1:0]      pg_ff, pg_in, rem_ff, rem_in, lim_ff, lim_in;
   logic [PG_W-1:0]      len_ff, len_in, run_ff, run_in, start_ff, start_in;
   logic [31:0]          addr_ff, addr_in;
   logic [CNT_W-1:0]     chg_ff, chg_in, used_ff, used_in;
   logic [WORD_BITS-1:0] wrd_ff, wrd_in;
   logic [WIW-1:0]       widx_ff, widx_in, fill_ff, fill_in;
   logic                 wval_ff, wval_in;

   logic [PG_W-1:0]      pg_word, pg_inc, pg_next, found_pg;
   logic [WIW-1:0]       need_idx;
   logic [WSH-1:0]       pg_bit;
   logic                 cur_bit, hit, in_rng, is_apply, done_now, need, miss;
   logic                 mem_we;
   logic [WIW-1:0]       mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [PG_W+15:0]     found_byte;

   // page lookup against the cached word
   always_comb begin
      pg_word  = pg_ff >> WSH;
      need_idx = pg_word[WIW-1:0];
      pg_bit   = pg_ff[WSH-1:0];
      cur_bit  = wrd_ff[pg_bit];
      hit      = wval_ff && (widx_ff == need_idx);
      in_rng   = (pg_ff < total_i) && ((op_ff != OP_FREE) || (pg_ff >= PG_W'(floor_i)));
      is_apply = (op_ff == OP_SET) || (op_ff == OP_CLR) || (op_ff == OP_FREE);
      done_now = (op_ff == OP_NOP) || ((op_ff == OP_SEARCH) && (pg_ff >= lim_ff))
                 || (is_apply && (rem_ff == '0));
      need     = (op_ff == OP_SEARCH) || in_rng;
      miss     = !done_now && need && !hit;
      pg_inc   = pg_ff + PG_W'(1);
      // run frees wrap within the 32-bit address space
      pg_next  = many_ff ? PG_W'(pg_inc[AP_W-1:0]) : pg_inc;
      found_pg = (run_ff == '0) ? pg_ff : start_ff;
      found_byte = (PG_W+16)'(found_pg) << PAGE_SHIFT;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_FILL: begin
            if (fill_ff == LAST_W) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (!cmd_empty_i) state_in = BK_RUN;
         end
         BK_RUN: begin
            if (done_now) state_in = BK_DONE;
            else if (miss) state_in = BK_LOAD;
         end
         BK_LOAD: begin
            state_in = BK_RUN;
         end
         BK_DONE: begin
            if (!rsp_full_i) state_in = BK_IDLE;
         end
      endcase
      if (cfg_fill_i) state_in = BK_FILL;
   end

   // datapath
   always_comb begin
      op_in    = op_ff;
      many_in  = many_ff;
      stat_in  = stat_ff;
      pg_in    = pg_ff;
      rem_in   = rem_ff;
      lim_in   = lim_ff;
      len_in   = len_ff;
      run_in   = run_ff;
      start_in = start_ff;
      addr_in  = addr_ff;
      chg_in   = chg_ff;
      used_in  = used_ff;
      wrd_in   = wrd_ff;
      widx_in  = widx_ff;
      wval_in  = wval_ff;
      fill_in  = fill_ff;
      unique case (state_ff)
         BK_FILL: begin
            fill_in = fill_ff + WIW'(1);
            used_in = CNT_W'(total_i);
            wval_in = 1'b0;
         end
         BK_IDLE: begin
            op_in    = cmd_i.op;
            many_in  = cmd_i.many;
            stat_in  = cmd_i.status;
            pg_in    = cmd_i.first;
            rem_in   = cmd_i.rem;
            lim_in   = cmd_i.lim;
            len_in   = cmd_i.len;
            run_in   = '0;
            start_in = '0;
            addr_in  = '0;
            chg_in   = '0;
         end
         BK_RUN: begin
            if (miss) begin
               widx_in = need_idx;
            end else if (!done_now) begin
               if (op_ff == OP_SEARCH) begin
                  pg_in = pg_inc;
                  if (cur_bit) begin
                     run_in = '0;
                  end else if (run_ff + PG_W'(1) == len_ff) begin
                     // run found: switch to marking it used
                     op_in   = OP_SET;
                     pg_in   = found_pg;
                     rem_in  = len_ff;
                     addr_in = found_byte[31:0];
                  end else begin
                     if (run_ff == '0) start_in = pg_ff;
                     run_in = run_ff + PG_W'(1);
                  end
               end else begin
                  pg_in  = pg_next;
                  rem_in = rem_ff - PG_W'(1);
                  if (!in_rng) begin
                     if (op_ff == OP_FREE) stat_in = many_ff ? ST_SKIPPED : ST_INVALID;
                  end else if ((op_ff == OP_SET) && !cur_bit) begin
                     wrd_in[pg_bit] = 1'b1;
                     chg_in  = chg_ff + CNT_W'(1);
                     used_in = used_ff + CNT_W'(1);
                  end else if ((op_ff == OP_CLR) && cur_bit) begin
                     wrd_in[pg_bit] = 1'b0;
                     chg_in  = chg_ff + CNT_W'(1);
                     used_in = used_ff - CNT_W'(1);
                  end else if (op_ff == OP_FREE) begin
                     if (!cur_bit) begin
                        stat_in = many_ff ? ST_SKIPPED : ST_DOUBLE;
                     end else begin
                        wrd_in[pg_bit] = 1'b0;
                        chg_in  = chg_ff + CNT_W'(1);
                        used_in = used_ff - CNT_W'(1);
                     end
                  end
               end
            end else if (op_ff == OP_SEARCH) begin
               // search ran off its limit without a fitting run
               stat_in = ST_NOSPACE;
            end
         end
         BK_LOAD: begin
            wrd_in  = rd_ff;
            wval_in = 1'b1;
         end
         BK_DONE: begin
         end
      endcase
      if (cfg_fill_i) begin
         fill_in = '0;
         wval_in = 1'b0;
      end
   end

   assign cmd_pop_o   = (state_ff == BK_IDLE) && !cmd_empty_i && !cfg_fill_i;
   assign rsp_push_o  = (state_ff == BK_DONE) && !rsp_full_i;
   assign fill_busy_o = (state_ff == BK_FILL);

   always_comb begin
      rsp_o.status  = stat_ff;
      rsp_o.addr    = addr_ff;
      rsp_o.changed = chg_ff[16:0];
      rsp_o.used    = used_ff[16:0];
      rsp_o.free    = 17'(total_i - PG_W'(used_ff));
   end

   // write back the cached word on eviction, ones during the fill sweep
   assign mem_we    = (state_ff == BK_FILL) || ((state_ff == BK_RUN) && miss && wval_ff);
   assign mem_waddr = (state_ff == BK_FILL) ? fill_ff : widx_ff;
   assign mem_wdata = (state_ff == BK_FILL) ? '1 : wrd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[need_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FILL;
         fill_ff  <= '0;
         wval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         wval_ff  <= wval_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      many_ff  <= many_in;
      stat_ff  <= stat_in;
      pg_ff    <= pg_in;
      rem_ff   <= rem_in;
      lim_ff   <= lim_in;
      len_ff   <= len_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      addr_ff  <= addr_in;
      chg_ff   <= chg_in;
      used_ff  <= used_in;
      wrd_ff   <= wrd_in;
      widx_ff  <= widx_in;
   end

endmodule

// File: src/bpa_checker.sv
// bpa_checker: port-level assertions for the page allocator
// bound to bitmap_page_allocator_unit; depends on bpa_pkg

module bpa_checker
   import bpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_result_address,
   input logic [16:0] rsp_pages_changed,
   input logic [16:0] rsp_used_count
);

   // the bitmap sweep after reset blocks new items
   a_sweep_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("input open right after reset");

   // a failed request never reports an address
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |-> rsp_result_address == 32'd0)
      else $error("address on failed request");

   // refused requests change no page
   a_refused_no_change: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == ST_NOSPACE || rsp_status == ST_ZERO
                      || rsp_status == ST_INVALID))
      |-> rsp_pages_changed == 17'd0)
      else $error("refused request changed pages");

   // a waiting result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_used_count)))
      else $error("waiting result lost");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_chk (.*);
